// File: sv/ftsr_pkg.sv
// Shared types and constants of the flat triangle span rasterizer.
// No dependencies; the other files but the checker use it by scoped names.
package ftsr_pkg;

  localparam int COORD_W = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int MAX_ROWS = 64;
  localparam int PIX_W = COORD_W - COORD_FRAC_BITS;     // floored coordinate
  localparam int Y_W = PIX_W + 2;                       // room for +1 and diffs
  localparam int DEN_W = PIX_W + 1;                     // |dy| up to 4096
  localparam int NUM_W = PIX_W + SLOPE_FRAC_BITS;       // |dx| << frac
  localparam int SLOPE_W = NUM_W + 1;
  localparam int POS_W = 44;
  localparam int CNT_W = 7;
  localparam int DIV_CNT_W = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 11;
  localparam int COLOR_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: sv/ftsr_if.sv
// Handshake channels of the rasterizer: triangle in, span out, register write.
// Depends on ftsr_pkg.
interface ftsr_tri_if;
  logic                              valid;
  logic                              ready;
  logic signed [ftsr_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic [ftsr_pkg::COLOR_W-1:0]      fill_color;
  modport source(output valid, ax, ay, bx, by, cx, cy, fill_color, input ready);
  modport sink(input valid, ax, ay, bx, by, cx, cy, fill_color, output ready);
endinterface

interface ftsr_span_if;
  logic                         valid;
  logic                         ready;
  logic [5:0]                   row;
  logic [10:0]                  x_left;
  logic signed [11:0]           x_right;
  logic [ftsr_pkg::COLOR_W-1:0] span_color;
  logic                         last;
  modport source(output valid, row, x_left, x_right, span_color, last, input ready);
  modport sink(input valid, row, x_left, x_right, span_color, last, output ready);
endinterface

interface ftsr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ftsr_pkg::CFG_IDX_W-1:0]  index;
  logic [ftsr_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/ftsr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ftsr_pkg.
module ftsr_div (
  input  logic               clk,
  input  logic               rst,
  input  ftsr_pkg::div_req_t req,
  output ftsr_pkg::div_rsp_t rsp
);
  logic [ftsr_pkg::NUM_W-1:0]     quo;
  logic [ftsr_pkg::DEN_W-1:0]     rem;
  logic [ftsr_pkg::DEN_W-1:0]     den;
  logic [ftsr_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [ftsr_pkg::DEN_W:0]       trial;

  assign trial = {rem, quo[ftsr_pkg::NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= ftsr_pkg::DIV_CNT_W'(ftsr_pkg::NUM_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // subtract when the shifted remainder covers the divisor
        if (trial >= {1'b0, den}) begin
          rem <= ftsr_pkg::DEN_W'(trial - {1'b0, den});
          quo <= {quo[ftsr_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[ftsr_pkg::DEN_W-1:0];
          quo <= {quo[ftsr_pkg::NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

// File: sv/flat_triangle_span_rasterizer.sv
// Flat triangle span rasterizer: sorts and floors one triangle, divides its
// edge slopes and emits clipped spans. Depends on ftsr_pkg, ftsr_if, ftsr_div.
// Steps: four slopes through the divider (a flat edge skips its divide), then
// the row check and the multiply states M0, M1, M2 before the first span.
// Throughput: one span per cycle while the sink is ready; the lower half first
// passes M0 to M2 again; a new triangle waits for idle. Reset: idle, sizes 64.
module flat_triangle_span_rasterizer (
  input logic         clk,
  input logic         rst,
  ftsr_tri_if.sink    triangle,
  ftsr_span_if.source span,
  ftsr_cfg_if.sink    cfg
);
  localparam int PW = ftsr_pkg::PIX_W;
  localparam int YW = ftsr_pkg::Y_W;
  localparam int SW = ftsr_pkg::SLOPE_W;
  localparam int QW = ftsr_pkg::POS_W;
  localparam int CW = ftsr_pkg::CNT_W;
  localparam int FB = ftsr_pkg::SLOPE_FRAC_BITS;
  localparam int XW = QW - FB;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DSTART = 9'b000000010,
    S_DWAIT  = 9'b000000100,
    S_DNEXT  = 9'b000001000,
    S_CHK    = 9'b000010000,
    S_M0     = 9'b000100000,
    S_M1     = 9'b001000000,
    S_M2     = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [10:0] frame_width;
  logic [6:0]  frame_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd64;
      frame_height <= 7'd64;
    end else if (cfg.valid) begin
      case (cfg.index)
        ftsr_pkg::REG_FRAME_WIDTH:  frame_width <= cfg.data;
        ftsr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Vertex sort: top, middle, bottom by raw y; flat edges left to right.
  // Then floor to whole pixels and fix up a zero-height triangle.
  // ---------------------------------------------------------------------
  logic signed [ftsr_pkg::COORD_W-1:0] sx1, sy1, sx2, sy2, sx3, sy3, st;
  logic signed [PW-1:0] fx1, fx2, fx3, fy1, fy3;
  logic signed [YW-1:0] ny1, ny2, ny3;

  always_comb begin
    st  = '0;
    sx1 = triangle.ax; sy1 = triangle.ay;
    sx2 = triangle.bx; sy2 = triangle.by;
    sx3 = triangle.cx; sy3 = triangle.cy;
    if (sy2 < sy3) begin
      st = sx2; sx2 = sx3; sx3 = st;
      st = sy2; sy2 = sy3; sy3 = st;
    end
    if (sy1 < sy2 && sy1 > sy3) begin
      st = sx1; sx1 = sx2; sx2 = st;
      st = sy1; sy1 = sy2; sy2 = st;
    end else if (sy1 < sy2) begin
      st = sx1; sx1 = sx2; sx2 = sx3; sx3 = st;
      st = sy1; sy1 = sy2; sy2 = sy3; sy3 = st;
    end
    if (sy2 == sy3 && sx2 > sx3) begin
      st = sx2; sx2 = sx3; sx3 = st;
    end
    if (sy1 == sy2 && sx1 > sx2) begin
      st = sx1; sx1 = sx2; sx2 = st;
    end
    fx1 = sx1[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS];
    fx2 = sx2[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS];
    fx3 = sx3[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS];
    fy1 = sy1[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS];
    fy3 = sy3[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS];
    ny1 = YW'(fy1);
    ny2 = YW'($signed(sy2[ftsr_pkg::COORD_W-1:ftsr_pkg::COORD_FRAC_BITS]));
    ny3 = YW'(fy3);
    // zero height: lift the top one row, collapse the rest onto the row
    if (fy1 == fy3) begin
      ny1 = YW'(fy1) + YW'(1);
      ny2 = YW'(fy1);
      ny3 = YW'(fy1);
    end
  end

  // triangle held for the whole job
  logic signed [PW-1:0] x1, x2, x3;
  logic signed [YW-1:0] y1, y2, y3;
  logic [ftsr_pkg::COLOR_W-1:0] color;

  // ---------------------------------------------------------------------
  // Row counts of both halves, clipped to the frame.
  // ---------------------------------------------------------------------
  logic signed [YW-1:0] hgt, hm1, ytop1, ybot1, ytop2, ybot2, d1, d2;
  logic [CW-1:0] n1, n2, total;
  logic [CW:0]   nsum;

  always_comb begin
    hgt   = (frame_height > 7'(ftsr_pkg::MAX_ROWS)) ? YW'(ftsr_pkg::MAX_ROWS)
                                                    : YW'(frame_height);
    hm1   = hgt - YW'(1);
    ytop1 = (y1 < hm1) ? y1 : hm1;
    ybot1 = (y2 > 0) ? y2 : '0;
    d1    = ytop1 - ybot1 + YW'(1);
    n1    = (d1 > 0) ? d1[CW-1:0] : '0;
    ybot2 = (y3 + YW'(1) > 0) ? y3 + YW'(1) : '0;
    ytop2 = (y2 < hm1) ? y2 : hm1;
    d2    = ytop2 - ybot2;
    n2    = (d2 > 0) ? d2[CW-1:0] : '0;
    nsum  = {1'b0, n1} + {1'b0, n2};
    total = (nsum > (CW+1)'(ftsr_pkg::MAX_ROWS)) ? CW'(ftsr_pkg::MAX_ROWS)
                                                 : nsum[CW-1:0];
  end

  // ---------------------------------------------------------------------
  // Slope setup: four divisions through the shared divider.
  // idx 0/1: first half slopes p1l/p1r, idx 2/3: second half slopes p2l/p2r.
  // ---------------------------------------------------------------------
  logic [1:0] didx;
  logic signed [SW-1:0] p1l, p1r, p2l, p2r;
  logic signed [PW:0]   ddx;
  logic signed [YW-1:0] ddy;
  logic                 dcond;
  logic [PW:0]          dmag;
  logic                 dneg;
  logic signed [SW-1:0] dslope;
  ftsr_pkg::div_req_t   dreq;
  ftsr_pkg::div_rsp_t   drsp;

  always_comb begin
    case (didx)
      2'd0: begin
        dcond = (y2 != y1);
        ddx   = (PW+1)'(x2) - (PW+1)'(x1);
        ddy   = y1 - y2;
      end
      2'd1: begin
        dcond = (y3 != y1);
        ddx   = (PW+1)'(x3) - (PW+1)'(x1);
        ddy   = y1 - y3;
      end
      2'd2: begin
        dcond = (y1 != y3);
        ddx   = (PW+1)'(x1) - (PW+1)'(x3);
        ddy   = y1 - y3;
      end
      default: begin
        dcond = (y2 != y3);
        ddx   = (PW+1)'(x2) - (PW+1)'(x3);
        ddy   = y2 - y3;
      end
    endcase
    dneg = ddx[PW];
    dmag = dneg ? (PW+1)'(-ddx) : ddx;
    dreq.start = (state == S_DSTART) && dcond;
    dreq.num   = {dmag[PW-1:0], {FB{1'b0}}};
    dreq.den   = ddy[ftsr_pkg::DEN_W-1:0];
    dslope     = dneg ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
  end

  ftsr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  // ---------------------------------------------------------------------
  // Edge start positions: base + slope * clipped rows, one product a cycle.
  // ---------------------------------------------------------------------
  logic                 part;            // 0: top half, 1: bottom half
  logic signed [SW-1:0] msl, msr;
  logic signed [YW-1:0] mclip;
  logic signed [PW-1:0] mx;
  logic signed [SW+YW-1:0] mprod_l, mprod_r;
  logic signed [QW-1:0] prod, base, pl, pr, dl, dr;

  always_comb begin
    msl   = part ? p2l : p1l;
    msr   = part ? p2r : p1r;
    // the second half steps before each row: start one row further in
    mclip = part ? (ybot2 - y3) : (y1 - ytop1);
    mx    = part ? x3 : x1;
    mprod_l = msl * mclip;
    mprod_r = msr * mclip;
    base  = {{(QW-PW-FB){mx[PW-1]}}, mx, {FB{1'b0}}};
  end

  // ---------------------------------------------------------------------
  // Span formatting: floor left, ceil right, clamp.
  // ---------------------------------------------------------------------
  logic signed [QW-1:0] prc;
  logic signed [XW-1:0] xl, xr, wm1;
  logic [10:0]          xl_o;
  logic signed [11:0]   xr_o;

  always_comb begin
    prc = pr + QW'({FB{1'b1}});
    xl  = pl[QW-1:FB];
    xr  = prc[QW-1:FB];
    wm1 = XW'(frame_width) - XW'(1);
    if (xl < 0) xl_o = '0;
    else if (xl > XW'(2047)) xl_o = 11'd2047;
    else xl_o = xl[10:0];
    if (xr > wm1) xr = wm1;
    if (xr < -XW'(2048)) xr_o = -12'sd2048;
    else xr_o = xr[11:0];
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  logic signed [YW-1:0] yrow;
  logic [CW-1:0]        rem_rows, cnt;
  logic                 take;

  assign triangle.ready = (state == S_IDLE);
  assign take = !span.valid || span.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      span.valid <= 1'b0;
    end else begin
      // drop the held span once the sink takes it, unless a new one follows
      if (span.valid && span.ready && state != S_EMIT) span.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (triangle.valid) begin
            x1 <= fx1; x2 <= fx2; x3 <= fx3;
            y1 <= ny1; y2 <= ny2; y3 <= ny3;
            color <= triangle.fill_color;
            p1l <= '0; p1r <= '0;
            didx  <= 2'd0;
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= dcond ? S_DWAIT : S_DNEXT;
        end
        S_DWAIT: begin
          if (drsp.done) begin
            case (didx)
              2'd0: p1l <= dslope;
              2'd1: p1r <= dslope;
              2'd2: p2l <= dslope;
              default: p2r <= dslope;
            endcase
            state <= S_DNEXT;
          end
        end
        S_DNEXT: begin
          // order each half's slopes; second half inherits skipped edges
          if (didx == 2'd1) begin
            p1l <= (p1l > p1r) ? p1r : p1l;
            p1r <= (p1l > p1r) ? p1l : p1r;
            p2l <= (p1l > p1r) ? p1r : p1l;
            p2r <= (p1l > p1r) ? p1l : p1r;
          end
          if (didx == 2'd3) begin
            p2l <= (p2l > p2r) ? p2r : p2l;
            p2r <= (p2l > p2r) ? p2l : p2r;
            state <= S_CHK;
          end else begin
            didx  <= didx + 2'd1;
            state <= S_DSTART;
          end
        end
        S_CHK: begin
          cnt  <= '0;
          part <= (n1 == '0);
          state <= (total == '0) ? S_IDLE : S_M0;
        end
        S_M0: begin
          prod  <= QW'(mprod_l);
          state <= S_M1;
        end
        S_M1: begin
          pl    <= base + prod;
          prod  <= QW'(mprod_r);
          state <= S_M2;
        end
        S_M2: begin
          pr       <= base + prod;
          dl       <= QW'(msl);
          dr       <= QW'(msr);
          yrow     <= part ? ybot2 : ytop1;
          rem_rows <= part ? n2 : n1;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (take) begin
            span.valid      <= 1'b1;
            span.row        <= yrow[5:0];
            span.x_left     <= xl_o;
            span.x_right    <= xr_o;
            span.span_color <= color;
            span.last       <= (cnt + CW'(1) == total);
            pl       <= pl + dl;
            pr       <= pr + dr;
            yrow     <= part ? yrow + YW'(1) : yrow - YW'(1);
            cnt      <= cnt + CW'(1);
            rem_rows <= rem_rows - CW'(1);
            if (cnt + CW'(1) == total) begin
              state <= S_IDLE;
            end else if (rem_rows == CW'(1)) begin
              part  <= 1'b1;
              state <= S_M0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/ftsr_checker.sv
// Port-level checks of the flat triangle span rasterizer, bound to its top.
// Depends on flat_triangle_span_rasterizer and ftsr_if.
module ftsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        tri_valid,
  input logic        tri_ready,
  input logic        span_valid,
  input logic        span_ready,
  input logic [5:0]  span_row,
  input logic [10:0] span_x_left,
  input logic        span_last
);
  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_ready |=> span_valid && $stable(span_row)
      && $stable(span_x_left) && $stable(span_last))
    else $error("stalled span changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tri_valid && tri_ready |=> !tri_ready)
    else $error("triangle port ready right after a transaction");

  a_span_needs_job: assert property (@(posedge clk) disable iff (rst)
    $rose(span_valid) |-> !$past(tri_ready))
    else $error("span appeared without a triangle in progress");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !span_valid)
    else $error("span valid after reset");
endmodule

bind flat_triangle_span_rasterizer ftsr_checker u_ftsr_checker (
  .clk(clk),
  .rst(rst),
  .tri_valid(triangle.valid),
  .tri_ready(triangle.ready),
  .span_valid(span.valid),
  .span_ready(span.ready),
  .span_row(span.row),
  .span_x_left(span.x_left),
  .span_last(span.last)
);

// File: bench/flat_triangle_span_rasterizer_tb.sv
// Self-checking bench for flat_triangle_span_rasterizer: drives triangles and
// register writes, predicts spans in SystemVerilog and scoreboards them.
// Depends on ftsr_pkg, ftsr_if and the rasterizer RTL.
module flat_triangle_span_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic [31:0]        color;
  } tri_t;

  typedef struct {
    logic [5:0]         row;
    logic [10:0]        xl;
    logic signed [11:0] xr;
    logic [31:0]        color;
    logic               last;
  } span_t;

  localparam longint CYCLE_LIMIT = 2_000_000;
  // index that names no register
  localparam logic [ftsr_pkg::CFG_IDX_W-1:0] REG_UNKNOWN = 4'd9;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftsr_tri_if  tri_ch();
  ftsr_span_if span_ch();
  ftsr_cfg_if  cfg_ch();

  flat_triangle_span_rasterizer dut (
    .clk(clk), .rst(rst), .triangle(tri_ch.sink), .span(span_ch.source),
    .cfg(cfg_ch.sink)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tri_t  tri_q[$];
  span_t span_exp_q[$];
  int    errors = 0;
  longint cycles = 0;
  bit    feeding_done = 1'b0;
  bit    tri_taken = 1'b0;
  bit    span_taken = 1'b0;

  // shadow copies of the frame registers
  logic [10:0] shadow_width = 11'd64;
  logic [6:0]  shadow_height = 7'd64;

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint edge_slope(longint dx, longint dy);
    longint ady;
    ady = dy < 0 ? -dy : dy;
    return (dx * (longint'(1) << ftsr_pkg::SLOPE_FRAC_BITS)) / ady;
  endfunction

  // Clip and saturate one span, queue it as expected.
  function automatic void push_span(longint y, longint pl, longint pr, longint w,
                                    logic [31:0] color, ref int n);
    longint one, xl, xr;
    span_t s;
    one = longint'(1) << ftsr_pkg::SLOPE_FRAC_BITS;
    xl = fdiv(pl, one);
    xr = -fdiv(-pr, one);
    if (n >= 64) return;
    if (xl < 0) xl = 0;
    if (xl > 2047) xl = 2047;
    if (xr > w - 1) xr = w - 1;
    if (xr < -2048) xr = -2048;
    if (xr > 2047) xr = 2047;
    s.row = y[5:0];
    s.xl = xl[10:0];
    s.xr = xr[11:0];
    s.color = color;
    s.last = 1'b0;
    span_exp_q.push_back(s);
    n++;
  endfunction

  // Sort, floor, divide slopes and walk both halves of the triangle.
  function automatic void predict_spans(tri_t t);
    longint px1, py1, px2, py2, px3, py3, tmp, ox, oy;
    longint x1, x2, x3, y1, y2, y3, h, w, one, dl, dr, pl, pr, clip, ytop, ybot;
    int n;
    n = 0;
    px1 = t.ax; py1 = t.ay; px2 = t.bx; py2 = t.by; px3 = t.cx; py3 = t.cy;
    if (py2 < py3) begin
      tmp = px2; px2 = px3; px3 = tmp;
      tmp = py2; py2 = py3; py3 = tmp;
    end
    if (py1 < py2 && py1 > py3) begin
      tmp = px1; px1 = px2; px2 = tmp;
      tmp = py1; py1 = py2; py2 = tmp;
    end else if (py1 < py2 && py1 <= py3) begin
      ox = px1; oy = py1;
      px1 = px2; py1 = py2;
      px2 = px3; py2 = py3;
      px3 = ox; py3 = oy;
    end
    if (py2 == py3 && px2 > px3) begin
      tmp = px2; px2 = px3; px3 = tmp;
    end
    if (py1 == py2 && px1 > px2) begin
      tmp = px1; px1 = px2; px2 = tmp;
    end
    x1 = fdiv(px1, 16); y1 = fdiv(py1, 16);
    x2 = fdiv(px2, 16); y2 = fdiv(py2, 16);
    x3 = fdiv(px3, 16); y3 = fdiv(py3, 16);
    // zero height: lift the top row by one
    if (y1 == y3) begin
      y1 += 1;
      y3 = y1 - 1;
      y2 = y3;
    end
    h = shadow_height;
    if (h > ftsr_pkg::MAX_ROWS) h = ftsr_pkg::MAX_ROWS;
    w = shadow_width;
    one = longint'(1) << ftsr_pkg::SLOPE_FRAC_BITS;
    dl = 0;
    dr = 0;
    if (y2 != y1) dl = edge_slope(x2 - x1, y2 - y1);
    if (y3 != y1) dr = edge_slope(x3 - x1, y3 - y1);
    if (dl > dr) begin
      tmp = dl; dl = dr; dr = tmp;
    end
    if (y1 < 0 || y3 >= h) return;
    // upper half, top vertex down to the middle row
    clip = y1 - h + 1;
    if (clip < 0) clip = 0;
    pl = x1 * one + dl * clip;
    pr = x1 * one + dr * clip;
    ytop = y1 - clip;
    ybot = y2 > 0 ? y2 : 0;
    for (longint y = ytop; y >= ybot; y--) begin
      push_span(y, pl, pr, w, t.color, n);
      pl += dl;
      pr += dr;
    end
    // lower half, bottom vertex up to below the middle row
    if (y1 != y3) dl = edge_slope(x1 - x3, y1 - y3);
    if (y2 != y3) dr = edge_slope(x2 - x3, y2 - y3);
    if (dl > dr) begin
      tmp = dl; dl = dr; dr = tmp;
    end
    clip = (y3 + 1 < 0) ? -(y3 + 1) : 0;
    pl = x3 * one + dl * clip;
    pr = x3 * one + dr * clip;
    ybot = (y3 + 1 > 0) ? y3 + 1 : 0;
    ytop = (y2 < h - 1) ? y2 : h - 1;
    for (longint y = ybot; y < ytop; y++) begin
      pl += dl;
      pr += dr;
      push_span(y, pl, pr, w, t.color, n);
    end
    if (n > 0) span_exp_q[$].last = 1'b1;
  endfunction

  // Driver: present queued triangles at the falling edge, with a random gap
  // after each accepted one; predict only once the transaction is accepted.
  int   tri_gap = 0;
  tri_t tri_cur;
  initial begin
    tri_ch.valid = 1'b0;
    tri_ch.ax = '0; tri_ch.ay = '0; tri_ch.bx = '0;
    tri_ch.by = '0; tri_ch.cx = '0; tri_ch.cy = '0;
    tri_ch.fill_color = '0;
  end

  // Record the transactions of each rising edge for the falling-edge logic.
  always @(posedge clk) begin
    tri_taken = !rst && tri_ch.valid && tri_ch.ready;
    span_taken = !rst && span_ch.valid && span_ch.ready;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (tri_ch.valid && tri_taken) begin
        predict_spans(tri_cur);
        tri_ch.valid <= 1'b0;
        tri_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end else if (!tri_ch.valid) begin
        if (tri_gap > 0) begin
          tri_gap--;
        end else if (tri_q.size() > 0) begin
          tri_cur = tri_q.pop_front();
          tri_ch.ax <= tri_cur.ax; tri_ch.ay <= tri_cur.ay;
          tri_ch.bx <= tri_cur.bx; tri_ch.by <= tri_cur.by;
          tri_ch.cx <= tri_cur.cx; tri_ch.cy <= tri_cur.cy;
          tri_ch.fill_color <= tri_cur.color;
          tri_ch.valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each span at the rising edge; toggle ready on its own draw.
  int span_stall = 0;
  initial span_ch.ready = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (!rst && span_ch.valid && span_ch.ready) begin
      if (span_exp_q.size() == 0) begin
        $error("unexpected span row=%0d x_left=%0d", span_ch.row, span_ch.x_left);
        errors++;
      end else begin
        span_t e;
        e = span_exp_q.pop_front();
        if (span_ch.row !== e.row) begin
          $error("row exp %0d got %0d", e.row, span_ch.row); errors++;
        end
        if (span_ch.x_left !== e.xl) begin
          $error("x_left exp %0d got %0d", e.xl, span_ch.x_left); errors++;
        end
        if (span_ch.x_right !== e.xr) begin
          $error("x_right exp %0d got %0d", e.xr, span_ch.x_right); errors++;
        end
        if (span_ch.span_color !== e.color) begin
          $error("span_color exp %h got %h", e.color, span_ch.span_color); errors++;
        end
        if (span_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, span_ch.last); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      span_ch.ready <= 1'b0;
    end else if (span_taken) begin
      // draw the stall that precedes the next span
      span_stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (span_stall > 0) span_ch.ready <= 1'b0;
    end else if (span_stall > 0) begin
      span_stall--;
      if (span_stall == 0) span_ch.ready <= 1'b1;
    end else begin
      span_ch.ready <= 1'b1;
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_coord(bit near);
    // near: mostly land on or around the frame, else anywhere
    if (near) return 16'($signed($urandom_range(0, 1280)) - 128);
    return 16'($urandom);
  endfunction

  function automatic tri_t rand_tri(int mode);
    tri_t t;
    t.color = $urandom;
    case (mode)
      0: begin
        t.ax = 16'($urandom); t.ay = 16'($urandom); t.bx = 16'($urandom);
        t.by = 16'($urandom); t.cx = 16'($urandom); t.cy = 16'($urandom);
      end
      1: begin
        // flat top or flat bottom
        t.ax = rand_coord(1); t.ay = rand_coord(1); t.bx = rand_coord(1);
        t.by = t.ay; t.cx = rand_coord(1); t.cy = rand_coord(1);
      end
      default: begin
        t.ax = rand_coord(1); t.ay = rand_coord(1); t.bx = rand_coord(1);
        t.by = rand_coord(1); t.cx = rand_coord(1); t.cy = rand_coord(1);
      end
    endcase
    return t;
  endfunction

  function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                              logic [31:0] c);
    tri_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx);
    t.by = 16'(by); t.cx = 16'(cx); t.cy = 16'(cy); t.color = c;
    return t;
  endfunction

  task automatic cfg_write(logic [ftsr_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == ftsr_pkg::REG_FRAME_WIDTH) shadow_width = val;
    else if (idx == ftsr_pkg::REG_FRAME_HEIGHT) shadow_height = val[6:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold until every queued triangle is accepted and every span is back,
  // then let the block drain any triangle that gave no spans.
  task automatic drain();
    while (tri_q.size() > 0 || tri_ch.valid || span_exp_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      int m;
      m = $urandom_range(0, 9);
      tri_q.push_back(rand_tri(m == 0 ? 0 : (m < 3 ? 1 : 2)));
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset sizes first
    tri_q.push_back(mk(160, 800, 16, 16, 900, 300, 32'hFFFF_FFFF));
    tri_q.push_back(mk(16, 160, 400, 160, 200, 480, 32'h0000_0000));  // flat bottom
    tri_q.push_back(mk(400, 480, 16, 480, 200, 100, 32'hA5A5_5A5A));  // flat top
    tri_q.push_back(mk(100, 300, 500, 310, 900, 305, 32'h1234_5678)); // thin: floored rows 18 and 19
    tri_q.push_back(mk(100, 100, 100, 600, 100, 300, 32'h5A5A_A5A5)); // vertical
    tri_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32'h8000_0001));
    tri_q.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, 32'h7FFF_FFFE));
    tri_q.push_back(mk(0, -200, 50, -100, 90, -300, 32'h0F0F_0F0F));  // below frame
    tri_q.push_back(mk(0, 2000, 50, 1100, 90, 3000, 32'hF0F0_F0F0));  // above frame
    tri_q.push_back(mk(-5000, 500, 30000, 200, -20000, 900, 32'hCAFE_0001)); // saturate
    tri_q.push_back(mk(800, 200, 100, 900, 600, 600, 32'hCAFE_0002)); // inverted risk
    tri_q.push_back(mk(-1, -1, -17, 15, 15, -17, 32'hCAFE_0003));
    drain();

    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'd1);
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'd1);
    tri_q.push_back(mk(0, 0, 32, 8, 16, 31, 32'h1));
    tri_q.push_back(mk(-16, -16, 64, 40, 0, 20, 32'h2));
    drain();

    // zero width and zero height registers, bogus index
    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'd0);
    cfg_write(REG_UNKNOWN, 11'h7FF);
    tri_q.push_back(mk(0, 0, 320, 300, 160, 600, 32'h3));
    drain();
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'd0);
    tri_q.push_back(mk(0, 0, 320, 300, 160, 600, 32'h4));
    drain();

    // height above the row cap, widest frame, including all ones
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'd127);
    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'h7FF);
    tri_q.push_back(mk(-32768, 1100, 32767, -50, 500, 400, 32'h5));
    tri_q.push_back(mk(0, 1023, 16000, 0, 8000, 600, 32'h6));
    drain();

    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'd1024);
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'd64);
    run_random(160);
    drain();
    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'd37);
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'd20);
    run_random(160);
    drain();
    cfg_write(ftsr_pkg::REG_FRAME_WIDTH, 11'($urandom_range(1, 1024)));
    cfg_write(ftsr_pkg::REG_FRAME_HEIGHT, 7'($urandom_range(1, 64)));
    run_random(160);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
